[design/s20x_pkg.sv]
// ----------------------------------------------------------------------------
// s20x_pkg: shared types and helpers for the salsa20 16-bit word stream xor
// word layout of the input block, quarter-round schedule and rotations
// ----------------------------------------------------------------------------
package s20x_pkg;

   localparam int S20X_DOUBLE_ROUNDS = 10;
   localparam int S20X_QUARTERS      = 8;

   // low halves of the "expand 16-byte k" constant words
   localparam logic [15:0] SIGMA_W0  = {8'h78, 8'h65};
   localparam logic [15:0] SIGMA_W5  = {8'h64, 8'h6e};
   localparam logic [15:0] SIGMA_W10 = {8'h2d, 8'h36};
   localparam logic [15:0] SIGMA_W15 = {8'h65, 8'h74};

   typedef logic [31:0] word_type;
   typedef logic [3:0]  widx_type;

   typedef struct packed {
      logic [63:0] key_low;
      logic [63:0] key_high;
      logic [63:0] nonce_value;
   } key_type;

   typedef struct packed {
      logic        start;
      logic [15:0] blocknum;
   } hash_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } hash_stat_type;

   typedef struct packed {
      logic     en;
      widx_type addr;
   } ks_rd_type;

   function automatic word_type sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // initial value of state word idx, from its two low bytes only
   function automatic word_type word_init(input widx_type idx, input key_type k,
                                          input logic [15:0] blk);
      logic [15:0] h;
      case (idx)
         4'd0:    h = SIGMA_W0;
         4'd1:    h = k.key_low[15:0];
         4'd2:    h = k.key_low[47:32];
         4'd3:    h = k.key_high[15:0];
         4'd4:    h = k.key_high[47:32];
         4'd5:    h = SIGMA_W5;
         4'd6:    h = k.nonce_value[15:0];
         4'd7:    h = k.nonce_value[47:32];
         4'd8:    h = blk;
         4'd9:    h = 16'h0000;
         4'd10:   h = SIGMA_W10;
         4'd11:   h = k.key_low[15:0];
         4'd12:   h = k.key_low[47:32];
         4'd13:   h = k.key_high[15:0];
         4'd14:   h = k.key_high[47:32];
         default: h = SIGMA_W15;
      endcase
      return sext16(h);
   endfunction

   // word index j (a, b, c, d) of quarter qr: four column then four row quarters
   function automatic widx_type sched(input logic [2:0] qr, input logic [1:0] j);
      logic [15:0] q;
      case (qr)
         3'd0:    q = {4'd0,  4'd4,  4'd8,  4'd12};
         3'd1:    q = {4'd5,  4'd9,  4'd13, 4'd1};
         3'd2:    q = {4'd10, 4'd14, 4'd2,  4'd6};
         3'd3:    q = {4'd15, 4'd3,  4'd7,  4'd11};
         3'd4:    q = {4'd0,  4'd1,  4'd2,  4'd3};
         3'd5:    q = {4'd5,  4'd6,  4'd7,  4'd4};
         3'd6:    q = {4'd10, 4'd11, 4'd8,  4'd9};
         default: q = {4'd15, 4'd12, 4'd13, 4'd14};
      endcase
      case (j)
         2'd0:    return q[15:12];
         2'd1:    return q[11:8];
         2'd2:    return q[7:4];
         default: return q[3:0];
      endcase
   endfunction

   // rotate left by 7, 9, 13 or 18 for quarter-round step k
   function automatic word_type rot_step(input word_type x, input logic [1:0] k);
      case (k)
         2'd0:    return {x[24:0], x[31:25]};
         2'd1:    return {x[22:0], x[31:23]};
         2'd2:    return {x[18:0], x[31:19]};
         default: return {x[13:0], x[31:14]};
      endcase
   endfunction

endpackage

[design/s20x_if.sv]
// ----------------------------------------------------------------------------
// s20x_if: request and response channels
// valid/ready handshake with the byte payload
// ----------------------------------------------------------------------------
interface s20x_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_start;

   modport source (output valid, output data_byte, output buffer_start, input ready);
   modport sink   (input valid, input data_byte, input buffer_start, output ready);
endinterface

interface s20x_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink   (input valid, input out_byte, output ready);
endinterface

[design/s20x_hash.sv]
// ----------------------------------------------------------------------------
// s20x_hash: block generator and keystream buffer
// state words in a 16x32 memory, one quarter round at a time through a
// four-word working set; result block in a second 16x32 memory
// ----------------------------------------------------------------------------
module s20x_hash #(
   parameter int DOUBLE_ROUNDS = s20x_pkg::S20X_DOUBLE_ROUNDS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  s20x_pkg::key_type       key,
   input  s20x_pkg::hash_ctrl_type ctrl,
   output s20x_pkg::hash_stat_type stat,
   input  s20x_pkg::ks_rd_type     ks_rd,
   output s20x_pkg::word_type      ks_rdata
);
   import s20x_pkg::*;

   localparam int RW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
   localparam logic [RW-1:0] LAST_ROUND = RW'(DOUBLE_ROUNDS - 1);
   localparam logic [2:0] LAST_QR = 3'(S20X_QUARTERS - 1);

   localparam logic [2:0] HS_IDLE  = 3'd0;
   localparam logic [2:0] HS_INIT  = 3'd1;
   localparam logic [2:0] HS_LOAD  = 3'd2;
   localparam logic [2:0] HS_STEP  = 3'd3;
   localparam logic [2:0] HS_STORE = 3'd4;
   localparam logic [2:0] HS_FINAL = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [2:0]    sub_ff, sub_in;
   logic [2:0]    qr_ff, qr_in;
   logic [RW-1:0] round_ff, round_in;
   logic [15:0]   blk_ff, blk_in;
   word_type      q_ff [4];
   word_type      q_in [4];

   word_type z_mem  [16];
   word_type ks_mem [16];
   word_type z_rdata_ff;
   word_type ks_rdata_ff;

   logic     z_we, z_re, ks_we;
   widx_type z_waddr, z_raddr, ks_waddr, init_idx;
   word_type z_wdata, ks_wdata, init_word, mix;

   assign init_idx  = (state_ff == HS_INIT) ? cnt_ff[3:0] : cnt_ff[3:0] - 4'd1;
   assign init_word = word_init(init_idx, key, blk_ff);
   assign mix       = q_ff[1] ^ rot_step(q_ff[0] + q_ff[3], sub_ff[1:0]);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sub_in   = sub_ff;
      qr_in    = qr_ff;
      round_in = round_ff;
      blk_in   = blk_ff;
      for (int i = 0; i < 4; i++) q_in[i] = q_ff[i];
      z_we     = 1'b0;
      z_waddr  = cnt_ff[3:0];
      z_wdata  = init_word;
      z_re     = 1'b0;
      z_raddr  = cnt_ff[3:0];
      ks_we    = 1'b0;
      ks_waddr = init_idx;
      ks_wdata = z_rdata_ff + init_word;
      case (state_ff)
         HS_IDLE: begin
            if (ctrl.start) begin
               blk_in   = ctrl.blocknum;
               cnt_in   = 5'd0;
               state_in = HS_INIT;
            end
         end
         HS_INIT: begin
            z_we   = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff[3:0] == 4'd15) begin
               sub_in   = 3'd0;
               qr_in    = 3'd0;
               round_in = '0;
               state_in = HS_LOAD;
            end
         end
         HS_LOAD: begin
            // reads issued on sub 0..3, data shifted in on the following cycle
            if (sub_ff != 3'd4) begin
               z_re    = 1'b1;
               z_raddr = sched(qr_ff, sub_ff[1:0]);
            end
            if (sub_ff != 3'd0) begin
               q_in[3] = z_rdata_ff;
               q_in[2] = q_ff[3];
               q_in[1] = q_ff[2];
               q_in[0] = q_ff[1];
            end
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd4) begin
               sub_in   = 3'd0;
               state_in = HS_STEP;
            end
         end
         HS_STEP: begin
            // target word always sits in slot 1; rotate the set after each step
            q_in[0] = mix;
            q_in[1] = q_ff[2];
            q_in[2] = q_ff[3];
            q_in[3] = q_ff[0];
            sub_in  = sub_ff + 3'd1;
            if (sub_ff == 3'd3) begin
               sub_in   = 3'd0;
               state_in = HS_STORE;
            end
         end
         HS_STORE: begin
            z_we    = 1'b1;
            z_waddr = sched(qr_ff, sub_ff[1:0]);
            z_wdata = q_ff[0];
            q_in[0] = q_ff[1];
            q_in[1] = q_ff[2];
            q_in[2] = q_ff[3];
            q_in[3] = q_ff[0];
            sub_in  = sub_ff + 3'd1;
            if (sub_ff == 3'd3) begin
               sub_in   = 3'd0;
               qr_in    = qr_ff + 3'd1;
               state_in = HS_LOAD;
               if (qr_ff == LAST_QR) begin
                  if (round_ff == LAST_ROUND) begin
                     cnt_in   = 5'd0;
                     state_in = HS_FINAL;
                  end else begin
                     round_in = round_ff + RW'(1);
                  end
               end
            end
         end
         HS_FINAL: begin
            // feed-forward add, one word per cycle behind the read
            if (cnt_ff != 5'd16) begin
               z_re = 1'b1;
            end
            if (cnt_ff != 5'd0) begin
               ks_we = 1'b1;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               state_in = HS_IDLE;
            end
         end
         default: state_in = HS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         cnt_ff   <= 5'd0;
         sub_ff   <= 3'd0;
         qr_ff    <= 3'd0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sub_ff   <= sub_in;
         qr_ff    <= qr_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      for (int i = 0; i < 4; i++) q_ff[i] <= q_in[i];
   end

   always_ff @(posedge clock) begin
      if (z_we) z_mem[z_waddr] <= z_wdata;
      if (z_re) z_rdata_ff <= z_mem[z_raddr];
   end

   always_ff @(posedge clock) begin
      if (ks_we) ks_mem[ks_waddr] <= ks_wdata;
      if (ks_rd.en) ks_rdata_ff <= ks_mem[ks_rd.addr];
   end

   assign ks_rdata  = ks_rdata_ff;
   assign stat.busy = (state_ff != HS_IDLE);
   assign stat.done = (state_ff == HS_FINAL) && (cnt_ff == 5'd16);

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> state_ff == HS_IDLE)
      else $error("block start while generator busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> state_ff == HS_IDLE)
      else $error("generator did not return to idle after done");

   a_last_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == HS_STORE && sub_ff == 3'd3 && qr_ff == LAST_QR &&
       round_ff == LAST_ROUND) |=> (state_ff == HS_FINAL && cnt_ff == 5'd0))
      else $error("final add not entered after last double round");

endmodule

[design/salsa20_16bit_word_stream_xor_unit.sv]
// ----------------------------------------------------------------------------
// salsa20_16bit_word_stream_xor_unit: keystream xor, one byte per request
// csr port for key, nonce and start index; block generator with memories
// ----------------------------------------------------------------------------
// within a block, an accepted request passes the read and output states, and its response
//   is registered once the output register is free; a request that starts a new block
//   first waits for the generator: 16 init writes, 80 quarter rounds of load, step and
//   store on the state memory, and the feed-forward add
// the next request is taken only after the previous response has been loaded
// reset: synchronous; config registers and stream position clear to zero
// ----------------------------------------------------------------------------
module salsa20_16bit_word_stream_xor_unit #(
   parameter int DOUBLE_ROUNDS = s20x_pkg::S20X_DOUBLE_ROUNDS
) (
   input  logic        clock,
   input  logic        reset,
   s20x_req_if.sink    req_chan,
   s20x_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import s20x_pkg::*;

   // register indexes, one 64-bit register every 8 bytes
   localparam logic [1:0] REG_KEY_LOW   = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH  = 2'd1;
   localparam logic [1:0] REG_NONCE     = 2'd2;
   localparam logic [1:0] REG_START_IDX = 2'd3;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HASH = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   // configuration
   logic [63:0] key_low_ff, key_high_ff, nonce_ff;
   logic [31:0] start_idx_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   // request tracking
   logic [1:0]  state_ff, state_in;
   logic [31:0] byte_position_ff, byte_position_in;
   logic [31:0] item_pos_ff, item_pos_in;
   logic [7:0]  data_ff, data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;

   logic          req_accept, need_block, out_free;
   logic [31:0]   pos_eff;
   logic [7:0]    ks_byte;
   key_type       key;
   hash_ctrl_type hash_ctrl;
   hash_stat_type hash_stat;
   ks_rd_type     ks_rd;
   word_type      ks_rdata;

   // csr write and read
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff   <= 64'd0;
         key_high_ff  <= 64'd0;
         nonce_ff     <= 64'd0;
         start_idx_ff <= 32'd0;
      end else if (csr_write) begin
         case (csr_index)
            REG_KEY_LOW:   key_low_ff   <= csr_pwdata;
            REG_KEY_HIGH:  key_high_ff  <= csr_pwdata;
            REG_NONCE:     nonce_ff     <= csr_pwdata;
            REG_START_IDX: start_idx_ff <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_KEY_LOW:   csr_prdata = key_low_ff;
         REG_KEY_HIGH:  csr_prdata = key_high_ff;
         REG_NONCE:     csr_prdata = nonce_ff;
         REG_START_IDX: csr_prdata = {32'd0, start_idx_ff};
         default:       csr_prdata = 64'd0;
      endcase
   end

   assign key.key_low     = key_low_ff;
   assign key.key_high    = key_high_ff;
   assign key.nonce_value = nonce_ff;

   // one request in flight; a finished response may wait while the next is taken
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // buffer start reloads the position; a new block at a buffer start or a
   // 64-byte boundary
   assign pos_eff    = req_chan.buffer_start ? start_idx_ff : byte_position_ff;
   assign need_block = req_chan.buffer_start || (pos_eff[5:0] == 6'd0);

   assign hash_ctrl.start    = req_accept && need_block;
   assign hash_ctrl.blocknum = pos_eff[21:6];

   assign ks_rd.en   = (state_ff == ST_READ);
   assign ks_rd.addr = item_pos_ff[5:2];

   // little-endian byte of the keystream word
   assign ks_byte  = 8'(ks_rdata >> {item_pos_ff[1:0], 3'b000});
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in         = state_ff;
      byte_position_in = byte_position_ff;
      item_pos_in      = item_pos_ff;
      data_in          = data_ff;
      rsp_byte_in      = rsp_byte_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_pos_in      = pos_eff;
               byte_position_in = pos_eff + 32'd1;
               data_in          = req_chan.data_byte;
               state_in         = need_block ? ST_HASH : ST_READ;
            end
         end
         ST_HASH: begin
            if (hash_stat.done) state_in = ST_READ;
         end
         ST_READ: state_in = ST_OUT;
         ST_OUT: begin
            // keystream read data holds until the output register frees up
            if (out_free) begin
               rsp_byte_in  = data_ff ^ ks_byte;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         byte_position_ff <= 32'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         byte_position_ff <= byte_position_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_pos_ff <= item_pos_in;
      data_ff     <= data_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;

   s20x_hash #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .key      (key),
      .ctrl     (hash_ctrl),
      .stat     (hash_stat),
      .ks_rd    (ks_rd),
      .ks_rdata (ks_rdata)
   );

   a_block_wait: assert property (@(posedge clock) disable iff (reset)
      (req_accept && need_block) |=> state_ff == ST_HASH)
      else $error("request needing a block skipped generation");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> byte_position_ff == item_pos_ff + 32'd1)
      else $error("stream position did not advance by one");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("response not loaded when output register free");

endmodule
